FILE: rtl/core/elgamal_modexp_engine_core_macros.svh
// assertion helpers shared by the core
`ifndef ELGAMAL_MODEXP_ENGINE_CORE_MACROS_SVH
`define ELGAMAL_MODEXP_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define EMEC_ASSERT_IMP(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("emec assertion failed");

// next-cycle implication
`define EMEC_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("emec assertion failed");

`endif

FILE: rtl/core/emec_pkg.sv
package emec_pkg;

	localparam logic [1:0] REG_PRIME   = 2'd0;
	localparam logic [1:0] REG_GEN     = 2'd1;
	localparam logic [1:0] REG_PUBLIC  = 2'd2;
	localparam logic [1:0] REG_PRIVATE = 2'd3;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_E_RMSG,
		S_E_RGEN,
		S_E_RPUB,
		S_E_FIN,
		S_D_RC2,
		S_D_RC1,
		S_PW_CHK,
		S_PW_MUL,
		S_PW_SQ,
		S_D_EINIT,
		S_D_ECHK,
		S_D_EDIV,
		S_D_EMUL,
		S_D_FIN,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		PASS_G,
		PASS_E,
		PASS_D
	} pass_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_DIV_MSG,
		OP_DIV_C2,
		OP_DIV_GEN,
		OP_DIV_PUB,
		OP_DIV_C1,
		OP_DIV_EUC,
		OP_MUL_Z,
		OP_MUL_SQ,
		OP_MUL_FIN_ENC,
		OP_MUL_Q,
		OP_MUL_FIN_DEC
	} op_t;

	typedef struct packed {
		logic load;
		op_t  op;
		logic euc_init;
		logic fail;
		logic publish;
	} cmd_t;

	typedef struct packed {
		logic p_small;
		logic func;
		logic exp_zero;
		logic exp_lsb;
		logic r2_zero;
		logic r1_one;
		logic done;
	} sts_t;

endpackage

FILE: rtl/core/elgamal_modexp_engine_core.sv
// each modular multiply or reduction runs on one shared unit
// encrypt: reduce message mod p, then gen^r and pub^r by square-and-multiply, then message * pub^r
// decrypt: reduce c2 and c1, c1^d by square-and-multiply, Euclid inverse of it, then times c2
// throughput: one item in flight; next beat taken while a finished result waits at the output
// reset: asynchronous, clears control state and loads the register reset values
module elgamal_modexp_engine_core #(
	parameter int MOD_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  func,
	input  logic [MOD_BITS-1:0]   message,
	input  logic [MOD_BITS-1:0]   ephemeral_key,
	input  logic [MOD_BITS-1:0]   cipher_first,
	input  logic [MOD_BITS-1:0]   cipher_second,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [MOD_BITS-1:0]   first_value,
	output logic [MOD_BITS-1:0]   second_value,
	output logic                  status,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [((MOD_BITS > 32) ? 5 : 4)-1:0]   paddr,
	input  logic [((MOD_BITS > 32) ? 64 : 32)-1:0] pwdata,
	output logic [((MOD_BITS > 32) ? 64 : 32)-1:0] prdata,
	output logic                  pready
);

	localparam int DATA_W = (MOD_BITS > 32) ? 64 : 32;
	localparam int ADDR_W = (MOD_BITS > 32) ? 5 : 4;

	logic [MOD_BITS-1:0] prime_q, gen_q, pub_q, priv_q;
	logic [1:0]          reg_idx;
	emec_pkg::cmd_t      cmd;
	emec_pkg::sts_t      sts;

	assign reg_idx = paddr[ADDR_W-1:ADDR_W-2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_q <= MOD_BITS'(2);
			gen_q   <= '0;
			pub_q   <= '0;
			priv_q  <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				emec_pkg::REG_PRIME: prime_q <= pwdata[MOD_BITS-1:0];
				emec_pkg::REG_GEN: gen_q <= pwdata[MOD_BITS-1:0];
				emec_pkg::REG_PUBLIC: pub_q <= pwdata[MOD_BITS-1:0];
				default: priv_q <= pwdata[MOD_BITS-1:0];
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			emec_pkg::REG_PRIME: prdata = DATA_W'(prime_q);
			emec_pkg::REG_GEN: prdata = DATA_W'(gen_q);
			emec_pkg::REG_PUBLIC: prdata = DATA_W'(pub_q);
			default: prdata = DATA_W'(priv_q);
		endcase
	end

	emec_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	emec_dp #(
		.W (MOD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.p             (prime_q),
		.gen           (gen_q),
		.pub           (pub_q),
		.priv          (priv_q),
		.func          (func),
		.message       (message),
		.ephemeral_key (ephemeral_key),
		.cipher_first  (cipher_first),
		.cipher_second (cipher_second),
		.first_value   (first_value),
		.second_value  (second_value),
		.status        (status)
	);

endmodule

FILE: rtl/core/emec_dp.sv
module emec_dp #(
	parameter int W = 31
) (
	input  logic            clk,
	input  logic            arst_n,
	input  emec_pkg::cmd_t  cmd,
	output emec_pkg::sts_t  sts,
	input  logic [W-1:0]    p,
	input  logic [W-1:0]    gen,
	input  logic [W-1:0]    pub,
	input  logic [W-1:0]    priv,
	input  logic            func,
	input  logic [W-1:0]    message,
	input  logic [W-1:0]    ephemeral_key,
	input  logic [W-1:0]    cipher_first,
	input  logic [W-1:0]    cipher_second,
	output logic [W-1:0]    first_value,
	output logic [W-1:0]    second_value,
	output logic            status
);

	localparam int CNT_W = $clog2(W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

	function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
			input logic [W-1:0] m);
		logic [W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[W-1:0];
	endfunction

	logic           func_q;
	logic [W-1:0]   msg_in_q, eph_q, c1_in_q, c2_in_q;
	logic [W-1:0]   msg_q, base_q, z_q, exp_q;
	logic [W-1:0]   r1_q, r2_q, t1_q, t2_q, quo_q, er_q;
	logic [W-1:0]   first_q, second_q;
	logic           status_q;
	logic [W-1:0]   out_first_q, out_second_q;
	logic           out_status_q;

	logic                 run_q;
	logic [CNT_W-1:0]     cnt_q;
	emec_pkg::op_t        op_q;
	logic [W-1:0]         ua_q, ub_q, acc_q;

	logic           is_div;
	logic [W:0]     dv_t;
	logic           dv_ge;
	logic [W-1:0]   acc_n, ua_n, ub_n;
	logic           done;
	logic [W-1:0]   qm, sub_diff, sub_res;
	logic [W-1:0]   st_ua, st_ub;

	assign is_div = op_q inside {emec_pkg::OP_DIV_MSG, emec_pkg::OP_DIV_C2,
		emec_pkg::OP_DIV_GEN, emec_pkg::OP_DIV_PUB, emec_pkg::OP_DIV_C1,
		emec_pkg::OP_DIV_EUC};

	always_comb begin
		dv_t  = {acc_q, ub_q[W-1]};
		dv_ge = dv_t >= {1'b0, ua_q};
		if (is_div) begin
			acc_n = dv_ge ? W'(dv_t - {1'b0, ua_q}) : dv_t[W-1:0];
			ua_n  = ua_q;
			ub_n  = {ub_q[W-2:0], dv_ge};
		end else begin
			acc_n = ub_q[0] ? add_mod(acc_q, ua_q, p) : acc_q;
			ua_n  = add_mod(ua_q, ua_q, p);
			ub_n  = {1'b0, ub_q[W-1:1]};
		end
	end

	assign done = run_q && (cnt_q == CNT_LAST);

	assign qm       = (quo_q == p) ? '0 : quo_q;
	assign sub_diff = t1_q - acc_n;
	assign sub_res  = (t1_q >= acc_n) ? sub_diff : sub_diff + p;

	// operand select at start: divide uses ua as divisor, ub as dividend
	always_comb begin
		st_ua = p;
		st_ub = '0;
		case (cmd.op)
			emec_pkg::OP_DIV_MSG: st_ub = msg_in_q;
			emec_pkg::OP_DIV_C2: st_ub = c2_in_q;
			emec_pkg::OP_DIV_GEN: st_ub = gen;
			emec_pkg::OP_DIV_PUB: st_ub = pub;
			emec_pkg::OP_DIV_C1: st_ub = c1_in_q;
			emec_pkg::OP_DIV_EUC: begin
				st_ua = r2_q;
				st_ub = r1_q;
			end
			emec_pkg::OP_MUL_Z: begin
				st_ua = z_q;
				st_ub = base_q;
			end
			emec_pkg::OP_MUL_SQ: begin
				st_ua = base_q;
				st_ub = base_q;
			end
			emec_pkg::OP_MUL_FIN_ENC: begin
				st_ua = z_q;
				st_ub = msg_q;
			end
			emec_pkg::OP_MUL_Q: begin
				st_ua = qm;
				st_ub = t2_q;
			end
			emec_pkg::OP_MUL_FIN_DEC: begin
				st_ua = t1_q;
				st_ub = msg_q;
			end
			default: st_ua = p;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			op_q  <= emec_pkg::OP_NONE;
		end else if (cmd.op != emec_pkg::OP_NONE) begin
			run_q <= 1'b1;
			cnt_q <= '0;
			op_q  <= cmd.op;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op != emec_pkg::OP_NONE) begin
			ua_q  <= st_ua;
			ub_q  <= st_ub;
			acc_q <= '0;
		end else if (run_q) begin
			ua_q  <= ua_n;
			ub_q  <= ub_n;
			acc_q <= acc_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= func;
			msg_in_q <= message;
			eph_q    <= ephemeral_key;
			c1_in_q  <= cipher_first;
			c2_in_q  <= cipher_second;
			first_q  <= '0;
			second_q <= '0;
			status_q <= 1'b0;
		end
		if (cmd.euc_init) begin
			r1_q <= p;
			r2_q <= z_q;
			t1_q <= '0;
			t2_q <= W'(1);
		end
		if (cmd.fail) begin
			status_q <= 1'b1;
			first_q  <= '0;
		end
		if (cmd.publish) begin
			out_first_q  <= first_q;
			out_second_q <= second_q;
			out_status_q <= status_q;
		end
		if (done) begin
			case (op_q)
				emec_pkg::OP_DIV_MSG, emec_pkg::OP_DIV_C2: msg_q <= acc_n;
				emec_pkg::OP_DIV_GEN: begin
					base_q <= acc_n;
					z_q    <= W'(1);
					exp_q  <= eph_q;
				end
				emec_pkg::OP_DIV_PUB: begin
					first_q <= z_q;
					base_q  <= acc_n;
					z_q     <= W'(1);
					exp_q   <= eph_q;
				end
				emec_pkg::OP_DIV_C1: begin
					base_q <= acc_n;
					z_q    <= W'(1);
					exp_q  <= priv;
				end
				emec_pkg::OP_DIV_EUC: begin
					quo_q <= ub_n;
					er_q  <= acc_n;
				end
				emec_pkg::OP_MUL_Z: z_q <= acc_n;
				emec_pkg::OP_MUL_SQ: begin
					base_q <= acc_n;
					exp_q  <= {1'b0, exp_q[W-1:1]};
				end
				emec_pkg::OP_MUL_FIN_ENC: second_q <= acc_n;
				emec_pkg::OP_MUL_Q: begin
					r1_q <= r2_q;
					r2_q <= er_q;
					t1_q <= t2_q;
					t2_q <= sub_res;
				end
				emec_pkg::OP_MUL_FIN_DEC: first_q <= acc_n;
				default: msg_q <= msg_q;
			endcase
		end
	end

	always_comb begin
		sts.p_small  = p < W'(2);
		sts.func     = func_q;
		sts.exp_zero = exp_q == '0;
		sts.exp_lsb  = exp_q[0];
		sts.r2_zero  = r2_q == '0;
		sts.r1_one   = r1_q == W'(1);
		sts.done     = done;
	end

	assign first_value  = out_first_q;
	assign second_value = out_second_q;
	assign status       = out_status_q;

endmodule

FILE: rtl/core/emec_ctrl.sv
`include "elgamal_modexp_engine_core_macros.svh"

module emec_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  emec_pkg::sts_t  sts,
	output emec_pkg::cmd_t  cmd
);

	emec_pkg::state_t state_q, state_d;
	emec_pkg::pass_t  pass_q, pass_d;
	logic             issued_q, issued_d;
	logic             out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= emec_pkg::S_IDLE;
			pass_q      <= emec_pkg::PASS_G;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			pass_q      <= pass_d;
			issued_q    <= issued_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		emec_pkg::op_t    cur_op;
		emec_pkg::state_t after_st;
		emec_pkg::pass_t  pass_after;
		cur_op       = emec_pkg::OP_NONE;
		after_st     = state_q;
		pass_after   = pass_q;
		state_d      = state_q;
		pass_d       = pass_q;
		issued_d     = issued_q;
		cmd.load     = 1'b0;
		cmd.op       = emec_pkg::OP_NONE;
		cmd.euc_init = 1'b0;
		cmd.fail     = 1'b0;
		cmd.publish  = 1'b0;
		out_valid_d  = out_valid_q && out_stall;
		case (state_q)
			emec_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = emec_pkg::S_DISPATCH;
				end
			end
			emec_pkg::S_DISPATCH: begin
				if (sts.p_small) begin
					state_d = emec_pkg::S_DONE;
				end else if (sts.func) begin
					state_d = emec_pkg::S_D_RC2;
				end else begin
					state_d = emec_pkg::S_E_RMSG;
				end
			end
			emec_pkg::S_E_RMSG: begin
				cur_op   = emec_pkg::OP_DIV_MSG;
				after_st = emec_pkg::S_E_RGEN;
			end
			emec_pkg::S_E_RGEN: begin
				cur_op     = emec_pkg::OP_DIV_GEN;
				after_st   = emec_pkg::S_PW_CHK;
				pass_after = emec_pkg::PASS_G;
			end
			emec_pkg::S_E_RPUB: begin
				cur_op     = emec_pkg::OP_DIV_PUB;
				after_st   = emec_pkg::S_PW_CHK;
				pass_after = emec_pkg::PASS_E;
			end
			emec_pkg::S_E_FIN: begin
				cur_op   = emec_pkg::OP_MUL_FIN_ENC;
				after_st = emec_pkg::S_DONE;
			end
			emec_pkg::S_D_RC2: begin
				cur_op   = emec_pkg::OP_DIV_C2;
				after_st = emec_pkg::S_D_RC1;
			end
			emec_pkg::S_D_RC1: begin
				cur_op     = emec_pkg::OP_DIV_C1;
				after_st   = emec_pkg::S_PW_CHK;
				pass_after = emec_pkg::PASS_D;
			end
			emec_pkg::S_PW_CHK: begin
				if (sts.exp_zero) begin
					case (pass_q)
						emec_pkg::PASS_G: state_d = emec_pkg::S_E_RPUB;
						emec_pkg::PASS_E: state_d = emec_pkg::S_E_FIN;
						default: state_d = emec_pkg::S_D_EINIT;
					endcase
				end else if (sts.exp_lsb) begin
					state_d = emec_pkg::S_PW_MUL;
				end else begin
					state_d = emec_pkg::S_PW_SQ;
				end
			end
			emec_pkg::S_PW_MUL: begin
				cur_op   = emec_pkg::OP_MUL_Z;
				after_st = emec_pkg::S_PW_SQ;
			end
			emec_pkg::S_PW_SQ: begin
				cur_op   = emec_pkg::OP_MUL_SQ;
				after_st = emec_pkg::S_PW_CHK;
			end
			emec_pkg::S_D_EINIT: begin
				cmd.euc_init = 1'b1;
				state_d      = emec_pkg::S_D_ECHK;
			end
			emec_pkg::S_D_ECHK: begin
				if (!sts.r2_zero) begin
					state_d = emec_pkg::S_D_EDIV;
				end else if (sts.r1_one) begin
					state_d = emec_pkg::S_D_FIN;
				end else begin
					cmd.fail = 1'b1;
					state_d  = emec_pkg::S_DONE;
				end
			end
			emec_pkg::S_D_EDIV: begin
				cur_op   = emec_pkg::OP_DIV_EUC;
				after_st = emec_pkg::S_D_EMUL;
			end
			emec_pkg::S_D_EMUL: begin
				cur_op   = emec_pkg::OP_MUL_Q;
				after_st = emec_pkg::S_D_ECHK;
			end
			emec_pkg::S_D_FIN: begin
				cur_op   = emec_pkg::OP_MUL_FIN_DEC;
				after_st = emec_pkg::S_DONE;
			end
			emec_pkg::S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.publish = 1'b1;
					out_valid_d = 1'b1;
					state_d     = emec_pkg::S_IDLE;
				end
			end
			default: state_d = emec_pkg::S_IDLE;
		endcase
		if (cur_op != emec_pkg::OP_NONE) begin
			if (!issued_q) begin
				cmd.op   = cur_op;
				issued_d = 1'b1;
			end else if (sts.done) begin
				issued_d = 1'b0;
				state_d  = after_st;
				pass_d   = pass_after;
			end
		end
	end

	assign in_stall  = state_q != emec_pkg::S_IDLE;
	assign out_valid = out_valid_q;

	`EMEC_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state_q != emec_pkg::S_IDLE)
	`EMEC_ASSERT_IMP(a_done_needs_issue, sts.done, issued_q)
	`EMEC_ASSERT_NEXT(a_done_publishes, state_q == emec_pkg::S_DONE && !out_valid_q, out_valid_q)
	`EMEC_ASSERT_IMP(a_no_issue_in_idle, state_q == emec_pkg::S_IDLE, cmd.op == emec_pkg::OP_NONE)

endmodule
